// ===== rtl/core/cst_pkg.sv =====
// cst_pkg: shared constants for the contrast stretch block.
// No dependencies; used by the interfaces and every module in rtl/core.
package cst_pkg;

  // default grey value width
  localparam int PIXEL_BITS_DEF = 8;

  // configuration port
  localparam int CFG_DATA_BITS  = 8;
  localparam int CFG_INDEX_BITS = 1;

  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

  localparam cfg_index_t REG_OUT_MIN = 1'b0;
  localparam cfg_index_t REG_OUT_MAX = 1'b1;

  // input commands
  localparam logic CMD_MEASURE = 1'b0;
  localparam logic CMD_MAP     = 1'b1;

endpackage

// ===== rtl/core/cst_ifs.sv =====
// Valid/ready channels of the contrast stretch block: pixel items in, results out.
// Depends on cst_pkg for the default pixel width.
interface cst_pixel_if #(
  parameter int PIXEL_BITS = cst_pkg::PIXEL_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  command;
  logic [PIXEL_BITS-1:0] pixel;
  logic                  first;
  logic                  last;

  modport source (output valid, command, pixel, first, last, input ready);
  modport sink   (input valid, command, pixel, first, last, output ready);
endinterface

interface cst_result_if #(
  parameter int PIXEL_BITS = cst_pkg::PIXEL_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_out;
  logic                  last_out;

  modport source (output valid, pixel_out, last_out, input ready);
  modport sink   (input valid, pixel_out, last_out, output ready);
endinterface

// ===== rtl/core/cst_stats.sv =====
// cst_stats: running darkest and brightest grey values of the measure pass.
// Depends on cst_pkg for the default pixel width.
module cst_stats #(
  parameter int PIXEL_BITS = cst_pkg::PIXEL_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  update,
  input  logic                  first,
  input  logic [PIXEL_BITS-1:0] pixel,
  output logic [PIXEL_BITS-1:0] darkest,
  output logic [PIXEL_BITS-1:0] brightest
);

  // restart on first, otherwise widen the range to take in the pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      darkest   <= '1;
      brightest <= '0;
    end else if (update) begin
      if (first) begin
        darkest   <= pixel;
        brightest <= pixel;
      end else begin
        if (pixel < darkest)   darkest   <= pixel;
        if (pixel > brightest) brightest <= pixel;
      end
    end
  end

endmodule

// ===== rtl/core/cst_divider.sv =====
// cst_divider: restoring divider, one quotient bit per cycle through one
// compare-and-subtract unit. Depends on cst_pkg for the default pixel width.
module cst_divider #(
  parameter int PIXEL_BITS = cst_pkg::PIXEL_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [2*PIXEL_BITS+1:0] num,
  input  logic [PIXEL_BITS:0]     den,
  output logic                    done,
  output logic [PIXEL_BITS-1:0]   quotient
);

  localparam int CNT_BITS = $clog2(PIXEL_BITS + 1);

  logic                  busy;
  logic [CNT_BITS-1:0]   count;
  logic [PIXEL_BITS+1:0] rem;
  logic [PIXEL_BITS-1:0] low;
  logic [PIXEL_BITS+1:0] trial;
  logic [PIXEL_BITS+1:0] den_ext;
  logic                  fits;

  // shift the next numerator bit into the partial remainder and compare
  assign trial   = {rem[PIXEL_BITS:0], low[PIXEL_BITS-1]};
  assign den_ext = {1'b0, den};
  assign fits    = (trial >= den_ext);

  // control: count quotient bits, flag the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_BITS'(PIXEL_BITS);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: the upper numerator bits already sit below the divisor,
  // as the quotient fits in PIXEL_BITS bits
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= num[2*PIXEL_BITS+1:PIXEL_BITS];
      low      <= num[PIXEL_BITS-1:0];
      quotient <= '0;
    end else if (busy) begin
      rem      <= fits ? (trial - den_ext) : trial;
      low      <= low << 1;
      quotient <= PIXEL_BITS'({quotient, fits});
    end
  end

endmodule

// ===== rtl/core/contrast_stretch.sv =====
// contrast_stretch: two-pass min/max linear contrast stretch of grey pixels.
// Depends on cst_pkg, cst_ifs (channels), cst_stats and cst_divider.
//
// Usage: pixel items arrive on the pixels channel (valid/ready). A measure
// item (command 0) folds its pixel into the darkest/brightest statistics,
// restarting them when first is set; it gives no result.
// A map item (command 1) gives one result on the results channel: the pixel
// stretched from the measured range onto [out_min, out_max], rounded half up,
// with last copied to last_out. The output range is written through the
// wr_en/wr_index/wr_data port; the user must do so only while the block is
// idle, which the block itself does not enforce. A reversed range is swapped.
// Steps: a map item's operands are registered at acceptance; the sequencer
// then passes MUL (the multiply-add, divider start), DIV (quotient bits one
// by one in the shared compare-subtract divider, until its done flag loads
// the result) and HOLD (the output load). A flat image skips the divider.
// ready is high only while idle, so no new item is taken until HOLD is left.
// Reset clears the statistics (darkest all ones, brightest zero), sets the
// output range to 0 and 255 and empties the result register. If the receiver
// stalls, the result register holds its item; the next map result waits in
// the sequencer until the register frees, and no input is taken meanwhile.
module contrast_stretch #(
  parameter int PIXEL_BITS = cst_pkg::PIXEL_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  cst_pixel_if.sink                         pixels,
  cst_result_if.source                      results,
  input  logic                              wr_en,
  input  logic [cst_pkg::CFG_INDEX_BITS-1:0] wr_index,
  input  logic [cst_pkg::CFG_DATA_BITS-1:0]  wr_data
);

  localparam int NUM_BITS = 2 * PIXEL_BITS + 2;

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_HOLD = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  // configuration registers
  logic [PIXEL_BITS-1:0] out_min;
  logic [PIXEL_BITS-1:0] out_max;
  logic [PIXEL_BITS-1:0] cfg_value;

  assign cfg_value = PIXEL_BITS'(wr_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_min <= '0;
      out_max <= PIXEL_BITS'(255);
    end else if (wr_en) begin
      unique case (wr_index)
        cst_pkg::REG_OUT_MIN: out_min <= cfg_value;
        cst_pkg::REG_OUT_MAX: out_max <= cfg_value;
        default: ;
      endcase
    end
  end

  // input handshake
  logic accept;
  logic accept_measure;
  logic accept_map;

  assign pixels.ready   = (state == ST_IDLE);
  assign accept         = pixels.valid & pixels.ready;
  assign accept_measure = accept & (pixels.command == cst_pkg::CMD_MEASURE);
  assign accept_map     = accept & (pixels.command == cst_pkg::CMD_MAP);

  // statistics
  logic [PIXEL_BITS-1:0] darkest;
  logic [PIXEL_BITS-1:0] brightest;

  cst_stats #(.PIXEL_BITS(PIXEL_BITS)) u_stats (
    .clk       (clk),
    .rst       (rst),
    .update    (accept_measure),
    .first     (pixels.first),
    .pixel     (pixels.pixel),
    .darkest   (darkest),
    .brightest (brightest)
  );

  // operand preparation at acceptance: order the range, clamp the pixel
  logic [PIXEL_BITS-1:0] lo_o;
  logic [PIXEL_BITS-1:0] hi_o;
  logic [PIXEL_BITS-1:0] clamped;
  logic                  flat;

  assign lo_o    = (out_min > out_max) ? out_max : out_min;
  assign hi_o    = (out_min > out_max) ? out_min : out_max;
  assign flat    = (brightest <= darkest);
  assign clamped = (pixels.pixel < darkest)   ? darkest   :
                   (pixels.pixel > brightest) ? brightest : pixels.pixel;

  logic [PIXEL_BITS-1:0] base;
  logic [PIXEL_BITS-1:0] span_out;
  logic [PIXEL_BITS-1:0] offset;
  logic [PIXEL_BITS-1:0] spread;
  logic                  last_hold;
  logic [PIXEL_BITS-1:0] result;

  // multiply-add: 2*span_out*offset + spread, straight into the divider
  logic [2*PIXEL_BITS-1:0] product;
  logic [NUM_BITS-1:0]     num;
  logic [PIXEL_BITS:0]     den;

  assign product = span_out * offset;
  assign num     = {1'b0, product, 1'b0} + NUM_BITS'(spread);
  assign den     = {spread, 1'b0};

  logic                  div_start;
  logic                  div_done;
  logic [PIXEL_BITS-1:0] quotient;

  assign div_start = (state == ST_MUL);

  cst_divider #(.PIXEL_BITS(PIXEL_BITS)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .num      (num),
    .den      (den),
    .done     (div_done),
    .quotient (quotient)
  );

  // output slot free this cycle
  logic slot_free;

  assign slot_free = ~results.valid | results.ready;

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept_map) state_next = flat ? ST_HOLD : ST_MUL;
      ST_MUL:  state_next = ST_DIV;
      ST_DIV:  if (div_done) state_next = ST_HOLD;
      ST_HOLD: if (slot_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // hold the operands of a map item
  always_ff @(posedge clk) begin
    if (accept_map) begin
      base      <= lo_o;
      span_out  <= hi_o - lo_o;
      offset    <= clamped - darkest;
      spread    <= brightest - darkest;
      last_hold <= pixels.last;
      result    <= lo_o;
    end else if (state == ST_DIV && div_done) begin
      result <= base + quotient;
    end
  end

  // result register: load from the sequencer, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (state == ST_HOLD && slot_free) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_HOLD && slot_free) begin
      results.pixel_out <= result;
      results.last_out  <= last_hold;
    end
  end

endmodule
